/* rtl/second_chance_frame_replacement_defines.svh */
// ---------------------------------------------------------------------------
// Second-chance frame replacement: assertion macros
// Shared property templates for the checker of the replacement list.
// ---------------------------------------------------------------------------
`ifndef SECOND_CHANCE_FRAME_REPLACEMENT_DEFINES_SVH
`define SECOND_CHANCE_FRAME_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define SCFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scfr: same-cycle property failed");

// Next-cycle implication, sampled at the rising clock edge.
`define SCFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scfr: next-cycle property failed");

`endif

/* rtl/scfr_pkg.sv */
// ---------------------------------------------------------------------------
// Second-chance frame replacement package
// Widths, operation codes, microcode types and status shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

    localparam int FRAMES  = 64;
    localparam int FW      = $clog2(FRAMES);
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int OPC_W   = 2;
    localparam int FIDX_W  = 6;
    localparam int STEP_W  = 4;

    typedef enum logic [OPC_W-1:0] {
        OP_REG    = 2'd0,
        OP_UNREG  = 2'd1,
        OP_TOUCH  = 2'd2,
        OP_VICTIM = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        A_NOP,
        A_LOAD_HEAD,
        A_UNLINK,
        A_APPEND,
        A_SET_ACC,
        A_FIN,
        A_FIN_VIC
    } t_act;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_EN,
        C_EMPTY,
        C_NOT_ACC
    } t_cond;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [STEP_W-1:0] tgt;
    } t_cword;

    typedef struct packed {
        logic en;
        logic empty;
        logic acc;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* rtl/scfr_req_if.sv */
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one list operation.
// ---------------------------------------------------------------------------
`default_nettype none

interface scfr_req_if;
    logic                        valid;
    logic                        ready;
    logic [scfr_pkg::OPC_W-1:0]  opcode;
    logic [scfr_pkg::FIDX_W-1:0] frame_index;

    modport source (output valid, output opcode, output frame_index, input ready);
    modport sink   (input valid, input opcode, input frame_index, output ready);
endinterface

`default_nettype wire

/* rtl/scfr_rsp_if.sv */
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the result of one list operation.
// ---------------------------------------------------------------------------
`default_nettype none

interface scfr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        was_listed;
    logic                        victim_found;
    logic [scfr_pkg::FIDX_W-1:0] evict_frame;

    modport source (output valid, output was_listed, output victim_found,
                    output evict_frame, input ready);
    modport sink   (input valid, input was_listed, input victim_found,
                    input evict_frame, output ready);
endinterface

`default_nettype wire

/* rtl/scfr_seq.sv */
// ---------------------------------------------------------------------------
// Microcode sequencer
// Step counter over a read-only program with conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module scfr_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [scfr_pkg::OPC_W-1:0] i_opcode,
    input  wire scfr_pkg::t_status          i_st,
    output scfr_pkg::t_act                  o_act,
    output logic                            o_idle
);

    // Each operation's routine starts at twice its opcode.
    localparam logic [scfr_pkg::STEP_W-1:0] S_VIC_LOOP = 4'd6;
    localparam logic [scfr_pkg::STEP_W-1:0] S_VIC_FIN  = 4'd10;
    localparam logic [scfr_pkg::STEP_W-1:0] S_FIN      = 4'd11;

    function automatic scfr_pkg::t_cword rom_word(input logic [scfr_pkg::STEP_W-1:0] s);
        scfr_pkg::t_cword w;
        w = '{act: scfr_pkg::A_FIN, cond: scfr_pkg::C_NEVER, tgt: S_FIN};
        unique case (s)
            4'd0:  w = '{act: scfr_pkg::A_NOP,       cond: scfr_pkg::C_NOT_EN,
                         tgt: S_FIN};
            4'd1:  w = '{act: scfr_pkg::A_APPEND,    cond: scfr_pkg::C_ALWAYS,
                         tgt: S_FIN};
            4'd2:  w = '{act: scfr_pkg::A_NOP,       cond: scfr_pkg::C_NOT_EN,
                         tgt: S_FIN};
            4'd3:  w = '{act: scfr_pkg::A_UNLINK,    cond: scfr_pkg::C_ALWAYS,
                         tgt: S_FIN};
            4'd4:  w = '{act: scfr_pkg::A_NOP,       cond: scfr_pkg::C_NOT_EN,
                         tgt: S_FIN};
            4'd5:  w = '{act: scfr_pkg::A_SET_ACC,   cond: scfr_pkg::C_ALWAYS,
                         tgt: S_FIN};
            4'd6:  w = '{act: scfr_pkg::A_LOAD_HEAD, cond: scfr_pkg::C_EMPTY,
                         tgt: S_FIN};
            4'd7:  w = '{act: scfr_pkg::A_NOP,       cond: scfr_pkg::C_NEVER,
                         tgt: S_FIN};
            4'd8:  w = '{act: scfr_pkg::A_UNLINK,    cond: scfr_pkg::C_NOT_ACC,
                         tgt: S_VIC_FIN};
            4'd9:  w = '{act: scfr_pkg::A_APPEND,    cond: scfr_pkg::C_ALWAYS,
                         tgt: S_VIC_LOOP};
            4'd10: w = '{act: scfr_pkg::A_FIN_VIC,   cond: scfr_pkg::C_NEVER,
                         tgt: S_FIN};
            default: w = '{act: scfr_pkg::A_FIN,     cond: scfr_pkg::C_NEVER,
                           tgt: S_FIN};
        endcase
        return w;
    endfunction

    logic                        r_busy;
    logic [scfr_pkg::STEP_W-1:0] r_pc;
    logic                        n_busy;
    logic [scfr_pkg::STEP_W-1:0] n_pc;
    scfr_pkg::t_cword            cw;
    logic                        is_fin;
    logic                        hold;
    logic                        take;

    assign cw     = rom_word(r_pc);
    assign is_fin = (cw.act == scfr_pkg::A_FIN) || (cw.act == scfr_pkg::A_FIN_VIC);
    assign hold   = is_fin && !i_st.out_free;
    assign o_act  = (r_busy && !hold) ? cw.act : scfr_pkg::A_NOP;
    assign o_idle = !r_busy;

    always_comb begin
        unique case (cw.cond)
            scfr_pkg::C_NEVER:   take = 1'b0;
            scfr_pkg::C_ALWAYS:  take = 1'b1;
            scfr_pkg::C_NOT_EN:  take = !i_st.en;
            scfr_pkg::C_EMPTY:   take = i_st.empty;
            scfr_pkg::C_NOT_ACC: take = !i_st.acc;
            default:             take = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = scfr_pkg::STEP_W'({i_opcode, 1'b0});
        end else if (r_busy) begin
            if (is_fin) begin
                if (i_st.out_free) begin
                    n_busy = 1'b0;
                end
            end else begin
                n_pc = take ? cw.tgt : r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

`default_nettype wire

/* rtl/scfr_dp.sv */
// ---------------------------------------------------------------------------
// Replacement list datapath
// Link memories, head/tail/count, per-frame flags and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module scfr_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [scfr_pkg::OPC_W-1:0]  i_opcode,
    input  wire logic [scfr_pkg::FIDX_W-1:0] i_frame_index,
    input  wire scfr_pkg::t_act              i_act,
    input  wire logic                        i_out_ready,
    output scfr_pkg::t_status                o_st,
    output logic                             o_valid,
    output logic                             o_was_listed,
    output logic                             o_victim_found,
    output logic [scfr_pkg::FIDX_W-1:0]      o_evict_frame
);

    localparam int FW    = scfr_pkg::FW;
    localparam int CNT_W = scfr_pkg::CNT_W;

    logic [FW-1:0]              r_next_mem [scfr_pkg::FRAMES];
    logic [FW-1:0]              r_prev_mem [scfr_pkg::FRAMES];
    logic [FW-1:0]              r_nxt_rd;
    logic [FW-1:0]              r_prv_rd;
    logic [FW-1:0]              r_head;
    logic [FW-1:0]              r_tail;
    logic [CNT_W-1:0]           r_cnt;
    logic [scfr_pkg::FRAMES-1:0] r_listed;
    logic [scfr_pkg::FRAMES-1:0] r_acc;
    logic [FW-1:0]              r_frm;
    logic                       r_en;
    logic                       r_was;
    logic                       r_ovalid;
    logic                       r_owas;
    logic                       r_ofound;
    logic [scfr_pkg::FIDX_W-1:0] r_ovic;

    logic [FW-1:0]              n_head;
    logic [FW-1:0]              n_tail;
    logic [CNT_W-1:0]           n_cnt;
    logic [scfr_pkg::FRAMES-1:0] n_listed;
    logic [scfr_pkg::FRAMES-1:0] n_acc;
    logic                       nxt_we;
    logic [FW-1:0]              nxt_wa;
    logic [FW-1:0]              nxt_wd;
    logic                       prv_we;
    logic [FW-1:0]              prv_wa;
    logic [FW-1:0]              prv_wd;
    logic                       in_range;
    logic                       hit;
    logic                       n_en;
    logic [FW-1:0]              in_frm;

    assign in_frm   = FW'(i_frame_index);
    assign in_range = ({26'd0, i_frame_index} < 32'(scfr_pkg::FRAMES));
    assign hit      = in_range && r_listed[in_frm];

    always_comb begin
        unique case (i_opcode)
            scfr_pkg::OP_REG:   n_en = in_range && !hit;
            scfr_pkg::OP_UNREG: n_en = hit;
            scfr_pkg::OP_TOUCH: n_en = in_range;
            default:            n_en = 1'b0;
        endcase
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_listed = r_listed;
        n_acc    = r_acc;
        nxt_we   = 1'b0;
        nxt_wa   = r_tail;
        nxt_wd   = r_frm;
        prv_we   = 1'b0;
        prv_wa   = r_frm;
        prv_wd   = r_tail;
        unique case (i_act)
            scfr_pkg::A_LOAD_HEAD: ;
            scfr_pkg::A_UNLINK: begin
                if (r_cnt <= CNT_W'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end else if (r_frm == r_head) begin
                    n_head = r_nxt_rd;
                end else if (r_frm == r_tail) begin
                    n_tail = r_prv_rd;
                end else begin
                    nxt_we = 1'b1;
                    nxt_wa = r_prv_rd;
                    nxt_wd = r_nxt_rd;
                    prv_we = 1'b1;
                    prv_wa = r_nxt_rd;
                    prv_wd = r_prv_rd;
                end
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 1'b1;
                end
                n_listed[r_frm] = 1'b0;
            end
            scfr_pkg::A_APPEND: begin
                if (r_cnt == '0) begin
                    n_head = r_frm;
                end else begin
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                end
                n_tail          = r_frm;
                n_cnt           = r_cnt + 1'b1;
                n_listed[r_frm] = 1'b1;
                n_acc[r_frm]    = 1'b0;
            end
            scfr_pkg::A_SET_ACC: begin
                n_acc[r_frm] = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            r_next_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we) begin
            r_prev_mem[prv_wa] <= prv_wd;
        end
        r_nxt_rd <= r_next_mem[r_frm];
        r_prv_rd <= r_prev_mem[r_frm];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_frm <= in_frm;
            r_en  <= n_en;
            r_was <= hit && (i_opcode != scfr_pkg::OP_VICTIM);
        end else if (i_act == scfr_pkg::A_LOAD_HEAD) begin
            r_frm <= r_head;
        end
        if (i_act == scfr_pkg::A_FIN || i_act == scfr_pkg::A_FIN_VIC) begin
            r_owas   <= r_was;
            r_ofound <= (i_act == scfr_pkg::A_FIN_VIC);
            r_ovic   <= (i_act == scfr_pkg::A_FIN_VIC) ? scfr_pkg::FIDX_W'(r_frm) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_listed <= '0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_listed <= n_listed;
            r_acc    <= n_acc;
            if (i_act == scfr_pkg::A_FIN || i_act == scfr_pkg::A_FIN_VIC) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_st.en       = r_en;
    assign o_st.empty    = (r_cnt == '0);
    assign o_st.acc      = r_acc[r_frm];
    assign o_st.out_free = !r_ovalid || i_out_ready;

    assign o_valid        = r_ovalid;
    assign o_was_listed   = r_owas;
    assign o_victim_found = r_ofound;
    assign o_evict_frame  = r_ovic;

endmodule

`default_nettype wire

/* rtl/second_chance_frame_replacement.sv */
// ---------------------------------------------------------------------------
// Second-chance frame replacement
// Clock-style replacement list of frames driven by a microcoded sequencer.
// ---------------------------------------------------------------------------
// The request channel i_req carries an opcode (register, unregister, touch,
// victim) and a frame index. The response channel o_rsp returns one result
// per request: was_listed, victim_found and evict_frame.
// A request is taken only while the sequencer is idle. Register, unregister
// and touch run a short routine; any of them on an out-of-range index, or a
// register or unregister on a frame that needs no change, takes the short path.
// A victim request on an empty list finds no victim; else it loads the head,
// waits for the registered link read and unlinks it. A head with its accessed
// flag set is appended to the tail with the flag cleared and the scan loops,
// else it is the victim; at most FRAMES + 1 frames are popped when all flags are set.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits; a finished request whose result
// cannot be written holds the sequencer until the receiver takes the old one.
// Reset empties the list and clears all listed and accessed flags at once.
// ---------------------------------------------------------------------------
`default_nettype none

module second_chance_frame_replacement (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    scfr_req_if.sink    i_req,
    scfr_rsp_if.source  o_rsp
);

    logic              start;
    logic              idle;
    scfr_pkg::t_act    act;
    scfr_pkg::t_status st;

    assign i_req.ready = idle;
    assign start       = i_req.valid && idle;

    scfr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_req.opcode),
        .i_st     (st),
        .o_act    (act),
        .o_idle   (idle)
    );

    scfr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_opcode       (i_req.opcode),
        .i_frame_index  (i_req.frame_index),
        .i_act          (act),
        .i_out_ready    (o_rsp.ready),
        .o_st           (st),
        .o_valid        (o_rsp.valid),
        .o_was_listed   (o_rsp.was_listed),
        .o_victim_found (o_rsp.victim_found),
        .o_evict_frame  (o_rsp.evict_frame)
    );

endmodule

`default_nettype wire

/* rtl/scfr_checker.sv */
// ---------------------------------------------------------------------------
// Replacement list port checker
// Properties seen on the request and response ports, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "second_chance_frame_replacement_defines.svh"

module scfr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_req_valid,
    input wire logic                        i_req_ready,
    input wire logic                        i_rsp_valid,
    input wire logic                        i_rsp_ready,
    input wire logic                        i_was_listed,
    input wire logic                        i_victim_found,
    input wire logic [scfr_pkg::FIDX_W-1:0] i_evict_frame
);

    // A victim result never reports a listed frame of its own.
    `SCFR_ASSERT_NOW(a_vic_not_was, i_clk, i_rst_n, i_rsp_valid && i_victim_found,
                     !i_was_listed)

    // Without a victim the frame field reads as zero.
    `SCFR_ASSERT_NOW(a_no_vic_zero, i_clk, i_rst_n, i_rsp_valid && !i_victim_found,
                     i_evict_frame == '0)

    // One request is in work at a time.
    `SCFR_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && i_req_ready,
                      !i_req_ready)

    // A stalled result holds its fields.
    `SCFR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready,
                      i_rsp_valid && $stable(i_evict_frame) && $stable(i_victim_found)
                      && $stable(i_was_listed))

endmodule

bind second_chance_frame_replacement scfr_checker u_scfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_was_listed   (o_rsp.was_listed),
    .i_victim_found (o_rsp.victim_found),
    .i_evict_frame  (o_rsp.evict_frame)
);

`default_nettype wire
